// ----- rtl/core/alignment_record_filter_core_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the alignment record filter core
// Clocked property wrappers with an active-low reset that disables the check.
// ----------------------------------------------------------------------------
`ifndef ALIGNMENT_RECORD_FILTER_CORE_MACROS_SVH
`define ALIGNMENT_RECORD_FILTER_CORE_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define ARF_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("alignment record filter check failed");

// Check that an implication holds at every rising clock edge outside reset.
`define ARF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	`ARF_ASSERT(label, clk, rst_n, (ante) |-> (cons))

`endif

// ----- rtl/core/arf_pkg.sv -----
// ----------------------------------------------------------------------------
// Alignment record filter package
// Shared reason codes, op codes, flag positions and the decision struct.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package arf_pkg;

	localparam int OP_CODE_W   = 4;
	localparam int OP_LEN_W    = 28;
	localparam int FLAG_W      = 16;
	localparam int POS_W       = 32;
	localparam int OUT_COUNT_W = 32;
	localparam int NUM_COUNTERS = 9;
	localparam int CIDX_W      = $clog2(NUM_COUNTERS);

	localparam logic [OP_CODE_W-1:0] OP_INS  = 4'd1;
	localparam logic [OP_CODE_W-1:0] OP_DEL  = 4'd2;
	localparam logic [OP_CODE_W-1:0] OP_SOFT = 4'd4;

	localparam int FL_PAIRED        = 0;
	localparam int FL_PROPER        = 1;
	localparam int FL_UNMAPPED      = 2;
	localparam int FL_MATE_UNMAPPED = 3;
	localparam int FL_REV           = 4;
	localparam int FL_MATE_REV      = 5;

	typedef enum logic [3:0] {
		RSN_VALID         = 4'd0,
		RSN_UNMAPPED      = 4'd1,
		RSN_IMPROPER      = 4'd2,
		RSN_MATE_UNMAPPED = 4'd3,
		RSN_DIFF_CONTIG   = 4'd4,
		RSN_SAME_STRAND   = 4'd5,
		RSN_INV_LEFT      = 4'd6,
		RSN_INV_RIGHT     = 4'd7,
		RSN_ALL_CLIPPED   = 4'd8,
		RSN_BIG_INS       = 4'd9,
		RSN_BIG_DEL       = 4'd10
	} reason_t;

	typedef struct packed {
		reason_t             reason;
		logic                counted;
		logic [CIDX_W-1:0]   cidx;
	} arf_decision_t;

	// Counter slot for a counted reason: slots skip the uncounted all-clipped code.
	function automatic logic [CIDX_W-1:0] reason_slot(input reason_t r);
		logic [3:0] v;
		v = r;
		if (r <= RSN_INV_RIGHT) begin
			reason_slot = CIDX_W'(v - 4'd1);
		end else begin
			reason_slot = CIDX_W'(v - 4'd2);
		end
	endfunction

endpackage

// ----- rtl/core/arf_classify.sv -----
// ----------------------------------------------------------------------------
// Alignment record classifier
// Tracks per-record op flags and decides the reject reason on the last op.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module arf_classify import arf_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  logic [OP_LEN_W-1:0]         indel_limit,
	input  logic [OP_CODE_W-1:0]        op_code,
	input  logic [OP_LEN_W-1:0]         op_length,
	input  logic                        has_op,
	input  logic                        last_op,
	input  logic [FLAG_W-1:0]           flag_bits,
	input  logic signed [POS_W-1:0]     ref_index,
	input  logic signed [POS_W-1:0]     mate_ref_index,
	input  logic signed [POS_W-1:0]     read_pos,
	input  logic signed [POS_W-1:0]     mate_pos,
	output arf_decision_t               decision
);

	logic unclipped_q, long_ins_q, long_del_q;
	logic unclipped_n, long_ins_n, long_del_n;
	logic over_limit, paired, rev, mrev;
	reason_t reason;

	assign over_limit  = op_length > indel_limit;
	assign unclipped_n = unclipped_q | (has_op & (op_code != OP_SOFT));
	assign long_ins_n  = long_ins_q |
		(has_op & over_limit & ((op_code == OP_INS) | (op_code == OP_SOFT)));
	assign long_del_n  = long_del_q | (has_op & over_limit & (op_code == OP_DEL));

	assign paired = flag_bits[FL_PAIRED];
	assign rev    = flag_bits[FL_REV];
	assign mrev   = flag_bits[FL_MATE_REV];

	always_comb begin
		if (flag_bits[FL_UNMAPPED]) begin
			reason = RSN_UNMAPPED;
		end else if (paired && !flag_bits[FL_PROPER]) begin
			reason = RSN_IMPROPER;
		end else if (paired && flag_bits[FL_MATE_UNMAPPED]) begin
			reason = RSN_MATE_UNMAPPED;
		end else if (paired && (ref_index != mate_ref_index)) begin
			reason = RSN_DIFF_CONTIG;
		end else if (paired && (rev == mrev)) begin
			reason = RSN_SAME_STRAND;
		end else if (paired && rev && (mate_pos > read_pos)) begin
			reason = RSN_INV_LEFT;
		end else if (paired && mrev && (mate_pos < read_pos)) begin
			reason = RSN_INV_RIGHT;
		end else if (!unclipped_n) begin
			reason = RSN_ALL_CLIPPED;
		end else if (long_ins_n) begin
			reason = RSN_BIG_INS;
		end else if (long_del_n) begin
			reason = RSN_BIG_DEL;
		end else begin
			reason = RSN_VALID;
		end
	end

	assign decision.reason  = reason;
	assign decision.counted = (reason != RSN_VALID) && (reason != RSN_ALL_CLIPPED);
	assign decision.cidx    = reason_slot(reason);

	// Accumulate over the record; clear once the decision is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unclipped_q <= 1'b0;
			long_ins_q  <= 1'b0;
			long_del_q  <= 1'b0;
		end else if (accept) begin
			unclipped_q <= unclipped_n & ~last_op;
			long_ins_q  <= long_ins_n & ~last_op;
			long_del_q  <= long_del_n & ~last_op;
		end
	end

endmodule

// ----- rtl/core/arf_counter_mem.sv -----
// ----------------------------------------------------------------------------
// Reject counter memory
// Synchronous counter store, registered read, per-entry valid bits for reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module arf_counter_mem import arf_pkg::*; #(
	parameter int COUNT_BITS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   rd_en,
	input  logic [CIDX_W-1:0]      rd_idx,
	output logic [COUNT_BITS-1:0]  rd_data,
	input  logic                   wr_en,
	input  logic [CIDX_W-1:0]      wr_idx,
	input  logic [COUNT_BITS-1:0]  wr_data
);

	logic [COUNT_BITS-1:0]   mem [NUM_COUNTERS];
	logic [NUM_COUNTERS-1:0] vld_q;
	logic [COUNT_BITS-1:0]   rd_data_q;
	logic                    rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_idx];
		end
	end

	// An entry never written reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_idx] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_idx];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_data_q : '0;

endmodule

// ----- rtl/core/alignment_record_filter_core.sv -----
// ----------------------------------------------------------------------------
// Alignment record filter core
// Classifies alignment records from a CIGAR op stream and counts rejects.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one CIGAR op per transaction.
//   The transaction with last_op set also carries flags, reference ids and
//   positions, and closes the record. Only that transaction yields a result
//   on the output channel (out_valid/out_ready): the pass/fail bit, the
//   reject reason and the updated saturating counter of that reason.
//   Throughput: one transaction per cycle, back to back, when the receiver
//   keeps out_ready high.
//   Pipeline: the closing input transaction enters stage 1, which reads
//   the counter memory (registered read); stage 2 bumps the count, writes
//   it back and loads the output register, from which the result shows.
//   A count bumped in the same cycle as the next read is forwarded.
//   Stall: while the output register holds an untaken result, stage 2 holds;
//   input stays open while stage 2 is empty or can drain to the output register.
//   Reset: counters read as zero (valid bits clear), record flags clear,
//   indel_limit returns to 10. cfg_wr_en writes indel_limit immediately.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module alignment_record_filter_core import arf_pkg::*; #(
	parameter int COUNT_BITS = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wr_en,
	input  logic [OP_LEN_W-1:0]      cfg_wr_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [OP_CODE_W-1:0]     op_code,
	input  logic [OP_LEN_W-1:0]      op_length,
	input  logic                     has_op,
	input  logic                     last_op,
	input  logic [FLAG_W-1:0]        flag_bits,
	input  logic signed [POS_W-1:0]  ref_index,
	input  logic signed [POS_W-1:0]  mate_ref_index,
	input  logic signed [POS_W-1:0]  read_pos,
	input  logic signed [POS_W-1:0]  mate_pos,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic                     is_valid,
	output logic [3:0]               reject_reason,
	output logic [OUT_COUNT_W-1:0]   reason_count
);

	logic [OP_LEN_W-1:0]   indel_limit_q;
	logic                  in_fire, rec_done, s1_fire;
	arf_decision_t         dec_in;

	logic                  valid_s1;
	arf_decision_t         dec_s1;
	logic                  fwd_hit_s1;
	logic [COUNT_BITS-1:0] fwd_cnt_s1;

	logic [COUNT_BITS-1:0] rd_cnt, cur_cnt, bumped;
	logic [63:0]           bumped_ext;

	logic                  out_valid_q;
	reason_t               out_reason_q;
	logic [OUT_COUNT_W-1:0] out_count_q;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			indel_limit_q <= OP_LEN_W'(10);
		end else if (cfg_wr_en) begin
			indel_limit_q <= cfg_wr_data;
		end
	end

	// Stage 2 drains when the output register is empty or being emptied.
	assign s1_fire  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || s1_fire;
	assign in_fire  = in_valid && in_ready;
	assign rec_done = in_fire && last_op;

	arf_classify u_classify (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (in_fire),
		.indel_limit    (indel_limit_q),
		.op_code        (op_code),
		.op_length      (op_length),
		.has_op         (has_op),
		.last_op        (last_op),
		.flag_bits      (flag_bits),
		.ref_index      (ref_index),
		.mate_ref_index (mate_ref_index),
		.read_pos       (read_pos),
		.mate_pos       (mate_pos),
		.decision       (dec_in)
	);

	// Read the counter as the record closes; write back as stage 2 drains.
	arf_counter_mem #(.COUNT_BITS(COUNT_BITS)) u_counters (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rec_done && dec_in.counted),
		.rd_idx  (dec_in.cidx),
		.rd_data (rd_cnt),
		.wr_en   (s1_fire && dec_s1.counted),
		.wr_idx  (dec_s1.cidx),
		.wr_data (bumped)
	);

	// Stage 1 register: decision plus forwarding of a write that lands on the
	// same edge as this record's memory read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= rec_done;
		end
	end

	always_ff @(posedge clk) begin
		if (rec_done) begin
			dec_s1     <= dec_in;
			fwd_hit_s1 <= s1_fire && dec_s1.counted && (dec_s1.cidx == dec_in.cidx);
			fwd_cnt_s1 <= bumped;
		end
	end

	// Saturating increment.
	assign cur_cnt    = fwd_hit_s1 ? fwd_cnt_s1 : rd_cnt;
	assign bumped     = (&cur_cnt) ? cur_cnt : cur_cnt + COUNT_BITS'(1);
	assign bumped_ext = 64'(bumped);

	// Output register: hold while the receiver stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			out_reason_q <= dec_s1.reason;
			out_count_q  <= dec_s1.counted ? bumped_ext[OUT_COUNT_W-1:0] : '0;
		end
	end

	assign out_valid     = out_valid_q;
	assign is_valid      = (out_reason_q == RSN_VALID);
	assign reject_reason = out_reason_q;
	assign reason_count  = out_count_q;

endmodule

// ----- rtl/core/arf_checker.sv -----
// ----------------------------------------------------------------------------
// Alignment record filter port checker
// Watches the top-level ports for output consistency and stall behavior.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "alignment_record_filter_core_macros.svh"

module arf_checker import arf_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic                   is_valid,
	input logic [3:0]             reject_reason,
	input logic [OUT_COUNT_W-1:0] reason_count
);

	// A stalled result holds.
	`ARF_ASSERT_IMPL(a_out_hold, clk, arst_n, out_valid && !out_ready, ##1 (out_valid && $stable(reject_reason) && $stable(reason_count)))

	// Pass bit agrees with the reason code.
	`ARF_ASSERT_IMPL(a_valid_matches_reason, clk, arst_n, out_valid, is_valid == (reject_reason == RSN_VALID))

	// Uncounted outcomes report a zero count.
	`ARF_ASSERT_IMPL(a_uncounted_zero, clk, arst_n, out_valid && (reject_reason == RSN_VALID || reject_reason == RSN_ALL_CLIPPED), reason_count == '0)

	// Counted rejects never report zero and never use an unknown code.
	`ARF_ASSERT_IMPL(a_counted_nonzero, clk, arst_n, out_valid && !is_valid && reject_reason != RSN_ALL_CLIPPED, reason_count != '0 && reject_reason <= RSN_BIG_DEL)

endmodule

bind alignment_record_filter_core arf_checker u_arf_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.is_valid      (is_valid),
	.reject_reason (reject_reason),
	.reason_count  (reason_count)
);

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// Alignment record filter core testbench
// Streams CIGAR op transactions into the core, predicts every record verdict
// with an in-bench model of the filter and its reject counters, and checks
// each output transaction against the oldest prediction in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
	import arf_pkg::*;

	localparam int TALLY_W     = 32;
	localparam int LATENCY_PAD = 6;
	localparam int HOLD_CYCLES = 120;

	// Op codes the package leaves unnamed
	localparam logic [OP_CODE_W-1:0] OP_MATCH       = 4'd0;
	localparam logic [OP_CODE_W-1:0] OP_SKIP        = 4'd3;
	localparam logic [OP_CODE_W-1:0] OP_HARD        = 4'd5;
	localparam logic [OP_CODE_W-1:0] OP_UNDEF_FIRST = 4'd9;

	localparam logic [OP_LEN_W-1:0] MAX_LEN = '1;

	// Flag masks built from the package bit positions
	localparam logic [FLAG_W-1:0] F_PAIRED        = 16'(1) << FL_PAIRED;
	localparam logic [FLAG_W-1:0] F_PROPER        = 16'(1) << FL_PROPER;
	localparam logic [FLAG_W-1:0] F_MATE_UNMAPPED = 16'(1) << FL_MATE_UNMAPPED;
	localparam logic [FLAG_W-1:0] F_REV           = 16'(1) << FL_REV;
	localparam logic [FLAG_W-1:0] F_MATE_REV      = 16'(1) << FL_MATE_REV;
	// Proper pair, read reverse, mate forward: passes when mate_pos <= read_pos
	localparam logic [FLAG_W-1:0] F_GOOD_PAIR     = F_PAIRED | F_PROPER | F_REV;

	typedef struct {
		logic [OP_CODE_W-1:0]   code;
		logic [OP_LEN_W-1:0]    len;
		bit                     has;
		bit                     last;
		logic [FLAG_W-1:0]      flags;
		logic signed [POS_W-1:0] ref_id;
		logic signed [POS_W-1:0] mate_ref_id;
		logic signed [POS_W-1:0] pos;
		logic signed [POS_W-1:0] mate_pos;
	} cigar_item_t;

	typedef struct {
		bit                     ok;
		reason_t                why;
		logic [OUT_COUNT_W-1:0] cnt;
	} verdict_t;

	// ------------------------------------------------------------------------
	// Record verdict predictor and in-order comparison of verdicts
	// ------------------------------------------------------------------------
	class record_scoreboard;
		logic [OP_LEN_W-1:0] limit;
		bit                  unclipped;
		bit                  long_ins;
		bit                  long_del;
		logic [TALLY_W-1:0]  tally [0:10];
		verdict_t            awaited [$];
		int                  errors;
		int                  seen;

		function new();
			errors = 0;
			seen = 0;
			limit = 10;
			unclipped = 0;
			long_ins = 0;
			long_del = 0;
			foreach (tally[i]) tally[i] = '0;
		endfunction

		function void set_limit(logic [OP_LEN_W-1:0] v);
			limit = v;
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		task report(string msg);
			$display("[%0t] mismatch: %s", $time, msg);
			errors++;
		endtask

		// Fold one accepted transaction into the record; close it on last_op.
		function void note_item(cigar_item_t it);
			bit       paired;
			bit       rev;
			bit       mrev;
			reason_t  why;
			verdict_t v;
			if (it.has) begin
				if (it.code != OP_SOFT) unclipped = 1;
				if ((it.code == OP_INS || it.code == OP_SOFT) && it.len > limit) long_ins = 1;
				if (it.code == OP_DEL && it.len > limit) long_del = 1;
			end
			if (!it.last) return;
			paired = it.flags[FL_PAIRED];
			rev = it.flags[FL_REV];
			mrev = it.flags[FL_MATE_REV];
			if (it.flags[FL_UNMAPPED]) why = RSN_UNMAPPED;
			else if (paired && !it.flags[FL_PROPER]) why = RSN_IMPROPER;
			else if (paired && it.flags[FL_MATE_UNMAPPED]) why = RSN_MATE_UNMAPPED;
			else if (paired && it.ref_id != it.mate_ref_id) why = RSN_DIFF_CONTIG;
			else if (paired && rev == mrev) why = RSN_SAME_STRAND;
			else if (paired && rev && it.mate_pos > it.pos) why = RSN_INV_LEFT;
			else if (paired && mrev && it.mate_pos < it.pos) why = RSN_INV_RIGHT;
			else if (!unclipped) why = RSN_ALL_CLIPPED;
			else if (long_ins) why = RSN_BIG_INS;
			else if (long_del) why = RSN_BIG_DEL;
			else why = RSN_VALID;
			v.ok = (why == RSN_VALID);
			v.why = why;
			v.cnt = '0;
			// Valid and all-clipped records have no counter
			if (why != RSN_VALID && why != RSN_ALL_CLIPPED) begin
				if (tally[why] != '1) tally[why] = tally[why] + 1'b1;
				v.cnt = tally[why][OUT_COUNT_W-1:0];
			end
			awaited.insert(awaited.size(), v);
			unclipped = 0;
			long_ins = 0;
			long_del = 0;
		endfunction

		task check_result(logic ok, logic [3:0] why, logic [OUT_COUNT_W-1:0] cnt);
			verdict_t v;
			seen++;
			if (awaited.size() == 0) begin
				report($sformatf("verdict %0d arrived with none predicted", seen));
				return;
			end
			v = awaited.pop_front();
			if (ok !== v.ok)
				report($sformatf("verdict %0d is_valid got %b want %b", seen, ok, v.ok));
			if (why !== 4'(v.why))
				report($sformatf("verdict %0d reject_reason got %0d want %0d (%s)",
					seen, why, v.why, v.why.name()));
			if (cnt !== v.cnt)
				report($sformatf("verdict %0d reason_count got %0d want %0d",
					seen, cnt, v.cnt));
		endtask
	endclass

	// ------------------------------------------------------------------------
	// Signals and the core
	// ------------------------------------------------------------------------
	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_wr_en = 1'b0;
	logic [OP_LEN_W-1:0]     cfg_wr_data = '0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic [OP_CODE_W-1:0]    op_code = '0;
	logic [OP_LEN_W-1:0]     op_length = '0;
	logic                    has_op = 1'b0;
	logic                    last_op = 1'b0;
	logic [FLAG_W-1:0]       flag_bits = '0;
	logic signed [POS_W-1:0] ref_index = '0;
	logic signed [POS_W-1:0] mate_ref_index = '0;
	logic signed [POS_W-1:0] read_pos = '0;
	logic signed [POS_W-1:0] mate_pos = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic                    is_valid;
	logic [3:0]              reject_reason;
	logic [OUT_COUNT_W-1:0]  reason_count;

	record_scoreboard    sb;
	logic [OP_LEN_W-1:0] cur_limit = 10;
	bit                  idle_on = 1;
	bit                  hold_request = 0;
	int                  items_sent = 0;

	alignment_record_filter_core #(
		.COUNT_BITS(TALLY_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op_code(op_code),
		.op_length(op_length),
		.has_op(has_op),
		.last_op(last_op),
		.flag_bits(flag_bits),
		.ref_index(ref_index),
		.mate_ref_index(mate_ref_index),
		.read_pos(read_pos),
		.mate_pos(mate_pos),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.is_valid(is_valid),
		.reject_reason(reject_reason),
		.reason_count(reason_count)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Sender side
	// ------------------------------------------------------------------------

	// Offer one transaction and hold it until the core takes it. Valid stays
	// high on return so a back-to-back transaction can follow at this edge.
	task automatic send_item(cigar_item_t it);
		in_valid <= 1'b1;
		op_code <= it.code;
		op_length <= it.len;
		has_op <= it.has;
		last_op <= it.last;
		flag_bits <= it.flags;
		ref_index <= it.ref_id;
		mate_ref_index <= it.mate_ref_id;
		read_pos <= it.pos;
		mate_pos <= it.mate_pos;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_item(it);
		items_sent++;
	endtask

	// Drop valid for a random burst now and then.
	task automatic sender_gap();
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
	endtask

	// Drop valid and hold until every predicted verdict has come out.
	// Always wait on the clock first so valid is never lowered and raised in one step.
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// Drain, then let the pipeline run dry: records still open cause no verdict.
	task automatic settle();
		wait_drained();
		repeat (LATENCY_PAD) @(posedge clk);
	endtask

	task automatic write_limit(logic [OP_LEN_W-1:0] v);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		sb.set_limit(v);
		cur_limit = v;
		cfg_wr_en <= 1'b0;
	endtask

	task automatic offer(logic [OP_CODE_W-1:0] code, logic [OP_LEN_W-1:0] len, bit has,
			bit last, logic [FLAG_W-1:0] flags, logic signed [POS_W-1:0] r,
			logic signed [POS_W-1:0] mr, logic signed [POS_W-1:0] p,
			logic signed [POS_W-1:0] mp);
		cigar_item_t it;
		it.code = code;
		it.len = len;
		it.has = has;
		it.last = last;
		it.flags = flags;
		it.ref_id = r;
		it.mate_ref_id = mr;
		it.pos = p;
		it.mate_pos = mp;
		send_item(it);
		sender_gap();
	endtask

	// ------------------------------------------------------------------------
	// Random content
	// ------------------------------------------------------------------------
	function automatic logic [OP_CODE_W-1:0] pick_code();
		case ($urandom_range(0, 11))
			0, 1, 2: return OP_MATCH;
			3, 4:    return OP_INS;
			5, 6:    return OP_DEL;
			7, 8:    return OP_SOFT;
			9:       return OP_SKIP;
			10:      return OP_HARD + 4'($urandom_range(0, 3));
			default: return OP_UNDEF_FIRST + 4'($urandom_range(0, 6));
		endcase
	endfunction

	// Lengths cluster on the limit boundary; clean records stay within it.
	function automatic logic [OP_LEN_W-1:0] pick_length(bit clean);
		if (clean) return OP_LEN_W'($urandom_range(cur_limit, 0));
		case ($urandom_range(0, 7))
			0:       return cur_limit;
			1:       return cur_limit + 1'b1;
			2:       return OP_LEN_W'($urandom());
			3:       return '0;
			4:       return MAX_LEN;
			default: return OP_LEN_W'($urandom_range(cur_limit, 0));
		endcase
	endfunction

	function automatic logic signed [POS_W-1:0] pick_coord();
		case ($urandom_range(0, 5))
			0:       return -32'sd1;
			1:       return {1'b0, 31'($urandom())};
			2:       return 32'sh7FFFFFFF;
			default: return $urandom_range(0, 1000);
		endcase
	endfunction

	function automatic logic signed [POS_W-1:0] pick_ref();
		case ($urandom_range(0, 5))
			0:       return -32'sd1;
			1:       return {1'b0, 31'($urandom())};
			default: return $urandom_range(0, 7);
		endcase
	endfunction

	function automatic cigar_item_t random_op(bit clean);
		cigar_item_t it;
		it.code = pick_code();
		it.len = pick_length(clean);
		it.has = ($urandom_range(0, 15) != 0);
		it.last = 0;
		// Flags and coordinates are don't-care before the closing transaction
		it.flags = 16'($urandom());
		it.ref_id = pick_ref();
		it.mate_ref_id = pick_ref();
		it.pos = pick_coord();
		it.mate_pos = pick_coord();
		return it;
	endfunction

	// Build a well-formed pair, then break one check now and then.
	function automatic cigar_item_t random_close(bit clean);
		cigar_item_t             it;
		bit                      rev;
		logic signed [POS_W-1:0] p;
		logic signed [POS_W-1:0] q;
		logic signed [POS_W-1:0] t;
		it = random_op(clean);
		it.has = 1;
		it.last = 1;
		rev = $urandom_range(0, 1);
		it.flags = 16'($urandom());
		it.flags[5:0] = '0;
		it.flags[FL_PAIRED] = 1'b1;
		it.flags[FL_PROPER] = 1'b1;
		if (rev) it.flags[FL_REV] = 1'b1;
		else it.flags[FL_MATE_REV] = 1'b1;
		it.mate_ref_id = it.ref_id;
		p = pick_coord();
		q = pick_coord();
		if (p < q) begin
			t = p;
			p = q;
			q = t;
		end
		// Reverse read sits at or right of its mate, forward read at or left
		it.pos = rev ? p : q;
		it.mate_pos = rev ? q : p;
		case ($urandom_range(0, 15))
			0: it.flags[FL_UNMAPPED] = 1'b1;
			1: it.flags[FL_PROPER] = 1'b0;
			2: it.flags[FL_MATE_UNMAPPED] = 1'b1;
			3: begin
				it.mate_ref_id = pick_ref();
				if (it.mate_ref_id == it.ref_id) it.mate_ref_id = (it.ref_id == -1) ? 0 : -1;
			end
			4: it.flags[FL_MATE_REV] = ~it.flags[FL_MATE_REV];
			5: begin
				t = it.pos;
				it.pos = it.mate_pos;
				it.mate_pos = t;
			end
			6: begin
				it.flags[5:1] = 5'($urandom());
				it.flags[FL_PAIRED] = 1'b0;
			end
			7: it.flags = 16'($urandom());
			default: ;
		endcase
		return it;
	endfunction

	function automatic cigar_item_t noise_item();
		cigar_item_t it;
		it.code = 4'($urandom());
		it.len = OP_LEN_W'($urandom());
		it.has = $urandom_range(0, 1);
		it.last = $urandom_range(0, 1);
		it.flags = 16'($urandom());
		it.ref_id = $urandom();
		it.mate_ref_id = $urandom();
		it.pos = $urandom();
		it.mate_pos = $urandom();
		return it;
	endfunction

	task automatic send_record();
		cigar_item_t it;
		bit          clean;
		bit          bare;
		int          n;
		clean = ($urandom_range(0, 9) < 7);
		bare = ($urandom_range(0, 19) == 0);
		n = $urandom_range(0, 5);
		repeat (n) begin
			it = random_op(clean);
			if (bare) it.has = 0;
			send_item(it);
			sender_gap();
		end
		it = random_close(clean);
		if (bare) it.has = 0;
		send_item(it);
		sender_gap();
	endtask

	// Mostly whole records, some raw noise; always close the last record so
	// the phase ends with nothing half built.
	task automatic random_phase(int quota);
		int start;
		start = items_sent;
		while (items_sent - start < quota) begin
			if ($urandom_range(0, 19) == 0) begin
				send_item(noise_item());
				sender_gap();
			end else begin
				send_record();
			end
		end
		send_record();
	endtask

	task automatic directed_records();
		// Limit is at its reset value of 10 here
		offer(OP_MATCH, 0, 1, 1, F_GOOD_PAIR, 0, 0, 100, 50);
		offer(OP_INS, MAX_LEN, 1, 1, F_GOOD_PAIR, 0, 0, 100, 50);
		offer(OP_DEL, 11, 1, 1, F_GOOD_PAIR, 0, 0, 100, 50);
		offer(OP_DEL, 10, 1, 1, F_GOOD_PAIR, 0, 0, 100, 50);
		offer(OP_INS, 10, 1, 1, F_GOOD_PAIR, 0, 0, 100, 50);
		// Long soft clip counts as a big insertion
		offer(OP_SOFT, 11, 1, 0, 0, 0, 0, 0, 0);
		offer(OP_MATCH, 5, 1, 1, F_GOOD_PAIR, 0, 0, 100, 50);
		// Soft clips only, then a record with no ops at all
		offer(OP_SOFT, 3, 1, 0, 0, 0, 0, 0, 0);
		offer(OP_SOFT, 4, 1, 1, F_GOOD_PAIR, 0, 0, 100, 50);
		offer(OP_MATCH, 0, 0, 1, F_GOOD_PAIR, 0, 0, 100, 50);
		// A transaction without an op must leave the record untouched
		offer(OP_INS, 20, 0, 0, 0, 0, 0, 0, 0);
		offer(OP_MATCH, 1, 1, 1, F_GOOD_PAIR, 0, 0, 100, 50);
		// One record per pair check, each closed by an op that has no length check
		offer(OP_SKIP, MAX_LEN, 1, 1, 16'hFFFF, 0, 0, 100, 50);
		offer(OP_HARD, MAX_LEN, 1, 1, F_PAIRED, 0, 0, 100, 50);
		offer(OP_HARD + 4'd1, MAX_LEN, 1, 1, F_PAIRED | F_PROPER | F_MATE_UNMAPPED,
			0, 0, 100, 50);
		offer(OP_HARD + 4'd2, MAX_LEN, 1, 1, F_GOOD_PAIR, 0, 1, 100, 50);
		offer(OP_HARD + 4'd3, MAX_LEN, 1, 1, F_GOOD_PAIR | F_MATE_REV, 0, 0, 100, 50);
		offer(OP_UNDEF_FIRST, MAX_LEN, 1, 1, F_GOOD_PAIR, 0, 0, 5, 6);
		offer(OP_UNDEF_FIRST + 4'd1, MAX_LEN, 1, 1, F_PAIRED | F_PROPER | F_MATE_REV,
			0, 0, 6, 5);
		// Unpaired read: mate checks are skipped however bad the mate bits look
		offer(OP_UNDEF_FIRST + 4'd2, MAX_LEN, 1, 1, 16'hFFFA, 3, 9, 100, 200);
		// Upper flag bits are ignored; coordinates at their extremes
		offer(OP_UNDEF_FIRST + 4'd3, MAX_LEN, 1, 1, 16'hFFD3, 32'sh7FFFFFFF,
			32'sh7FFFFFFF, 32'sh7FFFFFFF, -32'sd1);
		offer(OP_UNDEF_FIRST + 4'd5, MAX_LEN, 1, 0, 0, 0, 0, 0, 0);
		offer(OP_UNDEF_FIRST + 4'd6, MAX_LEN, 1, 0, 0, 0, 0, 0, 0);
		offer(OP_UNDEF_FIRST + 4'd4, MAX_LEN, 1, 1, F_PAIRED | F_PROPER | F_MATE_REV,
			-32'sd1, -32'sd1, -32'sd1, 32'sh7FFFFFFF);
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_records();

		// Limit zero: every nonzero insertion, clip or deletion is too long
		settle();
		write_limit('0);
		random_phase(130);

		// Largest limit; hold the receiver off so the core fills and stalls input
		settle();
		write_limit(MAX_LEN);
		random_phase(60);
		hold_request = 1;
		random_phase(80);

		// Small limit; pause the sender until the output is empty mid-phase
		settle();
		write_limit(OP_LEN_W'($urandom_range(1, 64)));
		random_phase(60);
		wait_drained();
		random_phase(70);

		settle();
		write_limit(OP_LEN_W'($urandom()));
		random_phase(130);

		settle();
		write_limit(OP_LEN_W'($urandom_range(0, 20)));
		random_phase(100);

		// Last stretch runs flat out on both sides
		idle_on = 0;
		settle();
		write_limit(10);
		random_phase(120);

		settle();
		if (sb.errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// ------------------------------------------------------------------------
	// Receiver side: ready bursts, idle bursts, and one long hold on request
	// ------------------------------------------------------------------------
	initial begin
		wait (arst_n);
		forever begin
			if (hold_request) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 0;
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	end

	// Check every output transaction with the values held at the edge
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready)
				sb.check_result(is_valid, reject_reason, reason_count);
		end
	end

	// Hard stop well past the slowest legal run
	initial begin
		#2000000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/arf_pkg.sv
rtl/core/arf_classify.sv
rtl/core/arf_counter_mem.sv
rtl/core/alignment_record_filter_core.sv
rtl/core/arf_checker.sv
test/testbench.sv
